@@ hw/rtl/lsfp_pkg.sv @@
// lsfp_pkg.sv: shared types, codes and color tables of the spectrum frame painter
`timescale 1ns / 1ps

package lsfp_pkg;

  localparam int BANDS = 7;

  // display_mode register codes
  localparam logic [2:0] MODE_OFF        = 3'd0;
  localparam logic [2:0] MODE_RB_VIOLET  = 3'd1;
  localparam logic [2:0] MODE_RB_RED     = 3'd2;
  localparam logic [2:0] MODE_LEVEL_BAR  = 3'd3;
  localparam logic [2:0] MODE_CENTRE_BAR = 3'd4;

  typedef enum logic [2:0] {
    JOB_DARK,
    JOB_RB_VIOLET,
    JOB_RB_RED,
    JOB_LEVEL_BAR,
    JOB_CENTRE_BAR
  } job_kind_t;

  typedef struct packed {
    job_kind_t             kind;
    logic [BANDS-1:0][7:0] amp;
    logic [6:0]            level;
  } lsfp_job_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
  } hsv_t;

  // floor(x / 255) for x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  function automatic hsv_t rb_violet(input logic [2:0] b);
    hsv_t c;
    case (b)
      3'd0:    c = '{hue: 8'd210, sat: 8'd200, val: 8'd230};
      3'd1:    c = '{hue: 8'd170, sat: 8'd255, val: 8'd255};
      3'd2:    c = '{hue: 8'd130, sat: 8'd200, val: 8'd230};
      3'd3:    c = '{hue: 8'd85,  sat: 8'd255, val: 8'd255};
      3'd4:    c = '{hue: 8'd43,  sat: 8'd210, val: 8'd255};
      3'd5:    c = '{hue: 8'd28,  sat: 8'd255, val: 8'd255};
      default: c = '{hue: 8'd0,   sat: 8'd255, val: 8'd255};
    endcase
    return c;
  endfunction

  function automatic hsv_t rb_red(input logic [2:0] b);
    hsv_t c;
    case (b)
      3'd0:    c = '{hue: 8'd0,   sat: 8'd255, val: 8'd255};
      3'd1:    c = '{hue: 8'd28,  sat: 8'd255, val: 8'd255};
      3'd2:    c = '{hue: 8'd43,  sat: 8'd210, val: 8'd255};
      3'd3:    c = '{hue: 8'd85,  sat: 8'd255, val: 8'd215};
      3'd4:    c = '{hue: 8'd130, sat: 8'd200, val: 8'd230};
      3'd5:    c = '{hue: 8'd170, sat: 8'd255, val: 8'd255};
      default: c = '{hue: 8'd210, sat: 8'd200, val: 8'd230};
    endcase
    return c;
  endfunction

  // green-yellow-red gradient, hue wraps modulo 256
  function automatic logic [7:0] bar_hue(
    input logic [5:0] k,
    input logic [5:0] g,
    input logic [5:0] y,
    input logic [5:0] cg,
    input logic [4:0] cy,
    input logic [6:0] cr
  );
    logic [12:0] t;
    logic [7:0]  h;
    if (k < g) begin
      t = 13'(cg) * 13'(k);
      h = 8'(13'd85 - t);
    end else if (7'(k) < 7'(g) + 7'(y)) begin
      t = 13'(cy) * (13'(k) - 13'(g));
      h = 8'(13'd50 - t);
    end else begin
      t = 13'(cr) * (13'(k) - 13'(g) - 13'(y) + 13'd1);
      h = 8'(13'd28 - t);
    end
    return h;
  endfunction

endpackage

@@ hw/rtl/lsfp_if.sv @@
// lsfp_if.sv: valid/ready channel interfaces for frames and LED colors
`timescale 1ns / 1ps

interface lsfp_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] band0_level;
  logic [7:0] band1_level;
  logic [7:0] band2_level;
  logic [7:0] band3_level;
  logic [7:0] band4_level;
  logic [7:0] band5_level;
  logic [7:0] band6_level;

  modport source (
    output valid, band0_level, band1_level, band2_level, band3_level,
           band4_level, band5_level, band6_level,
    input  ready
  );
  modport sink (
    input  valid, band0_level, band1_level, band2_level, band3_level,
           band4_level, band5_level, band6_level,
    output ready
  );
endinterface

interface lsfp_pixel_if;
  logic       valid;
  logic       ready;
  logic [5:0] led_index;
  logic [7:0] hue;
  logic [7:0] saturation;
  logic [7:0] brightness;
  logic       last_led;

  modport source (
    output valid, led_index, hue, saturation, brightness, last_led,
    input  ready
  );
  modport sink (
    input  valid, led_index, hue, saturation, brightness, last_led,
    output ready
  );
endinterface

@@ hw/rtl/lsfp_front.sv @@
// lsfp_front.sv: frame intake, mode register, peak search and bar level
`timescale 1ns / 1ps

module lsfp_front #(
  parameter int LED_COUNT = 30
) (
  input  logic              clk,
  input  logic              rst,
  lsfp_frame_if.sink        frame,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_wdata,
  output logic              push_valid,
  input  logic              push_ready,
  output lsfp_pkg::lsfp_job_t push_data
);
  import lsfp_pkg::*;

  localparam int LEN_FULL = LED_COUNT;
  localparam int LEN_HALF = LED_COUNT / 2;

  logic [2:0]            display_mode;
  logic                  full;
  job_kind_t             kind;
  logic [BANDS-1:0][7:0] amp;
  logic [7:0]            peak;

  logic [BANDS-1:0][7:0] amp_in;
  logic [7:0]            peak_in;
  job_kind_t             kind_in;
  logic [6:0]            len;
  logic [14:0]           scaled;
  logic [16:0]           lvl_t;

  assign amp_in = {frame.band6_level, frame.band5_level, frame.band4_level,
                   frame.band3_level, frame.band2_level, frame.band1_level,
                   frame.band0_level};

  always_comb begin
    peak_in = amp_in[0];
    for (int b = 1; b < BANDS; b++) begin
      if (amp_in[b] > peak_in) peak_in = amp_in[b];
    end
  end

  always_comb begin
    case (display_mode)
      MODE_RB_VIOLET:  kind_in = JOB_RB_VIOLET;
      MODE_RB_RED:     kind_in = JOB_RB_RED;
      MODE_LEVEL_BAR:  kind_in = JOB_LEVEL_BAR;
      MODE_CENTRE_BAR: kind_in = JOB_CENTRE_BAR;
      default:         kind_in = JOB_DARK;
    endcase
  end

  assign frame.ready = !full || push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_mode <= MODE_OFF;
      full         <= 1'b0;
    end else begin
      if (cfg_we) display_mode <= cfg_wdata;
      if (frame.valid && frame.ready) full <= 1'b1;
      else if (push_ready)            full <= 1'b0;
    end
    if (frame.valid && frame.ready) begin
      kind <= kind_in;
      amp  <= amp_in;
      peak <= peak_in;
    end
  end

  // level = floor(peak * len / 255)
  assign len    = (kind == JOB_CENTRE_BAR) ? 7'(LEN_HALF) : 7'(LEN_FULL);
  assign scaled = 15'(peak) * 15'(len);
  assign lvl_t  = 17'(scaled) + 17'(scaled[14:8]) + 17'd1;

  assign push_valid      = full;
  assign push_data.kind  = kind;
  assign push_data.amp   = amp;
  assign push_data.level = lvl_t[14:8];

endmodule

@@ hw/rtl/lsfp_queue.sv @@
// lsfp_queue.sv: two-entry job queue between intake and painter
`timescale 1ns / 1ps

module lsfp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  lsfp_pkg::lsfp_job_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output lsfp_pkg::lsfp_job_t pop_data
);
  import lsfp_pkg::*;

  lsfp_job_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
    if (do_push) mem[wr_ptr] <= push_data;
  end

endmodule

@@ hw/rtl/lsfp_back.sv @@
// lsfp_back.sv: per-LED color sequencer with two-stage output pipeline
`timescale 1ns / 1ps

module lsfp_back #(
  parameter int LED_COUNT = 30
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  output logic                job_ready,
  input  lsfp_pkg::lsfp_job_t job_data,
  lsfp_pixel_if.source        pixel
);
  import lsfp_pkg::*;

  localparam int G_RB   = LED_COUNT / 7;
  localparam int REM_RB = LED_COUNT - 7 * G_RB;
  localparam int FIRST  = G_RB + REM_RB - 1;

  localparam int L_F  = LED_COUNT;
  localparam int G_F  = L_F / 4;
  localparam int Y_F  = (3 * L_F) / 5;
  localparam int R_F  = L_F - G_F - Y_F;
  localparam int CG_F = 35 / ((G_F == 0) ? 1 : G_F);
  localparam int CY_F = 21 / ((Y_F == 0) ? 1 : Y_F);
  localparam int CR_F = 85 / ((R_F == 0) ? 1 : 3 * R_F);

  localparam int L_H  = LED_COUNT / 2;
  localparam int G_H  = L_H / 4;
  localparam int Y_H  = (3 * L_H) / 5;
  localparam int R_H  = L_H - G_H - Y_H;
  localparam int CG_H = 35 / ((G_H == 0) ? 1 : G_H);
  localparam int CY_H = 21 / ((Y_H == 0) ? 1 : Y_H);
  localparam int CR_H = 85 / ((R_H == 0) ? 1 : 3 * R_H);

  localparam logic ODD = 1'(LED_COUNT % 2);

  // sequencer
  logic       busy;
  lsfp_job_t  job;
  logic [5:0] idx;
  logic [2:0] band;
  logic [5:0] band_cnt;
  logic       idx_last;
  logic       adv;
  logic       issue;

  // stage 1
  logic        s1_valid;
  logic [5:0]  s1_idx;
  logic        s1_last;
  logic [7:0]  s1_hue;
  logic [7:0]  s1_sat;
  logic [15:0] s1_prod;
  logic        s1_scale;

  // output register
  logic       ov;
  logic [5:0] o_idx;
  logic [7:0] o_hue;
  logic [7:0] o_sat;
  logic [7:0] o_val;
  logic       o_last;

  // per-LED color
  hsv_t        rb;
  logic [7:0]  amp_sel;
  logic [5:0]  half;
  logic        mid;
  logic [5:0]  kc;
  logic [7:0]  hue_c;
  logic [7:0]  sat_c;
  logic [15:0] prod_c;
  logic        scale_c;

  assign idx_last  = (idx == 6'(LED_COUNT - 1));
  assign adv       = !ov || pixel.ready;
  assign issue     = busy && adv;
  assign job_ready = !busy || (adv && idx_last);

  assign rb      = (job.kind == JOB_RB_VIOLET) ? rb_violet(band) : rb_red(band);
  assign amp_sel = job.amp[band];
  assign half    = 6'(L_H);
  assign mid     = ODD && (idx == half);
  assign kc      = (idx < half) ? (half - 6'd1 - idx) : (idx - half - 6'(ODD));

  always_comb begin
    hue_c   = 8'd0;
    sat_c   = 8'd0;
    prod_c  = 16'd0;
    scale_c = 1'b0;
    unique case (job.kind)
      JOB_RB_VIOLET, JOB_RB_RED: begin
        hue_c   = rb.hue;
        sat_c   = rb.sat;
        prod_c  = 16'(amp_sel) * 16'(rb.val);
        scale_c = 1'b1;
      end
      JOB_LEVEL_BAR: begin
        hue_c  = bar_hue(idx, 6'(G_F), 6'(Y_F), 6'(CG_F), 5'(CY_F), 7'(CR_F));
        sat_c  = 8'd255;
        prod_c = ({1'b0, idx} < job.level) ? 16'd255 : 16'd0;
      end
      JOB_CENTRE_BAR: begin
        sat_c = 8'd255;
        if (mid) begin
          hue_c  = 8'd85;
          prod_c = (job.level != 7'd0) ? 16'd255 : 16'd0;
        end else begin
          hue_c  = bar_hue(kc, 6'(G_H), 6'(Y_H), 6'(CG_H), 5'(CY_H), 7'(CR_H));
          prod_c = ({1'b0, kc} < job.level) ? 16'd255 : 16'd0;
        end
      end
      default: begin
        hue_c = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      s1_valid <= 1'b0;
      ov       <= 1'b0;
    end else begin
      if (job_valid && job_ready) begin
        busy <= 1'b1;
      end else if (issue && idx_last) begin
        busy <= 1'b0;
      end
      if (adv) begin
        s1_valid <= issue;
        ov       <= s1_valid;
      end
    end

    if (job_valid && job_ready) begin
      job      <= job_data;
      idx      <= 6'd0;
      band     <= 3'd0;
      band_cnt <= 6'(FIRST);
    end else if (issue) begin
      idx <= idx + 6'd1;
      if (band_cnt == 6'd0) begin
        band_cnt <= 6'(G_RB - 1);
        if (band != 3'd6) band <= band + 3'd1;
      end else begin
        band_cnt <= band_cnt - 6'd1;
      end
    end

    if (adv) begin
      s1_idx   <= idx;
      s1_last  <= idx_last;
      s1_hue   <= hue_c;
      s1_sat   <= sat_c;
      s1_prod  <= prod_c;
      s1_scale <= scale_c;
      o_idx    <= s1_idx;
      o_last   <= s1_last;
      o_hue    <= s1_hue;
      o_sat    <= s1_sat;
      o_val    <= s1_scale ? div255(s1_prod) : s1_prod[7:0];
    end
  end

  assign pixel.valid      = ov;
  assign pixel.led_index  = o_idx;
  assign pixel.hue        = o_hue;
  assign pixel.saturation = o_sat;
  assign pixel.brightness = o_val;
  assign pixel.last_led   = o_last;

endmodule

@@ hw/rtl/led_spectrum_frame_painter_core.sv @@
// led_spectrum_frame_painter_core.sv: top level of the LED spectrum frame painter
`timescale 1ns / 1ps

// frame channel: one transfer carries seven 8-bit band amplitudes
// pixel channel: LED_COUNT transfers per frame, one HSV color per LED,
//   LED 0 first, last_led set on LED LED_COUNT-1
// cfg_we/cfg_wdata: write display_mode (0 off, 1 and 2 rainbow bands,
//   3 level bar, 4 centre bar, 5 to 7 off); write only while idle
// throughput: one LED color per cycle while the pixel output is not stalled;
//   frames stream back to back through the painter sequencer
// the first color of a frame passes the intake register, job queue,
//   color stage and output register
// the intake register and a two-entry job queue let up to three frames be
//   taken while the painter is busy
// pixel stall: the whole painter pipeline holds, the queue fills, then
//   frame.ready drops
// reset: display_mode goes to off, queue and pipeline empty
module led_spectrum_frame_painter_core #(
  parameter int LED_COUNT = 30
) (
  input  logic         clk,
  input  logic         rst,
  lsfp_frame_if.sink   frame,
  lsfp_pixel_if.source pixel,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_wdata
);
  import lsfp_pkg::*;

  logic      push_valid;
  logic      push_ready;
  lsfp_job_t push_data;
  logic      pop_valid;
  logic      pop_ready;
  lsfp_job_t pop_data;

  lsfp_front #(.LED_COUNT(LED_COUNT)) u_front (
    .clk        (clk),
    .rst        (rst),
    .frame      (frame),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  lsfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  lsfp_back #(.LED_COUNT(LED_COUNT)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .job_data  (pop_data),
    .pixel     (pixel)
  );

endmodule

@@ test/lsfp_color_checker.sv @@
// lsfp_color_checker.sv: predicts the LED colors of each accepted frame and checks the pixel stream
`timescale 1ns / 1ps

module lsfp_color_checker #(
  parameter int LED_COUNT = 30
) (
  input  logic       clk,
  input  logic       rst,
  lsfp_frame_if      frame,
  lsfp_pixel_if      pixel,
  input  logic       cfg_we,
  input  logic [2:0] cfg_wdata,
  output int         fail_count,
  output int         pending
);
  import lsfp_pkg::*;

  typedef struct packed {
    logic [5:0] led_index;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
    logic       last_led;
  } led_color_t;

  led_color_t expected_colors[$];
  logic [2:0] display_mode;
  int         errors;
  int         reported;

  function automatic logic [7:0] gradient_hue(input int k, input int len);
    int g;
    int y;
    int r;
    int cg;
    int cy;
    int cr;
    int h;
    g  = len / 4;
    y  = (len * 3) / 5;
    r  = len - g - y;
    cg = 35 / ((g == 0) ? 1 : g);
    cy = 21 / ((y == 0) ? 1 : y);
    cr = 85 / ((r == 0) ? 1 : 3 * r);
    if (k < g) begin
      h = 85 - cg * k;
    end else if (k < g + y) begin
      h = 50 - cy * (k - g);
    end else begin
      h = 28 - cr * (k - g - y + 1);
    end
    return h[7:0];
  endfunction

  // {hue, saturation, full-scale brightness} of a band
  function automatic logic [23:0] band_hsv(input bit red_first, input int b);
    logic [23:0] c;
    if (red_first) begin
      case (b)
        0:       c = {8'd0,   8'd255, 8'd255};
        1:       c = {8'd28,  8'd255, 8'd255};
        2:       c = {8'd43,  8'd210, 8'd255};
        3:       c = {8'd85,  8'd255, 8'd215};
        4:       c = {8'd130, 8'd200, 8'd230};
        5:       c = {8'd170, 8'd255, 8'd255};
        default: c = {8'd210, 8'd200, 8'd230};
      endcase
    end else begin
      case (b)
        0:       c = {8'd210, 8'd200, 8'd230};
        1:       c = {8'd170, 8'd255, 8'd255};
        2:       c = {8'd130, 8'd200, 8'd230};
        3:       c = {8'd85,  8'd255, 8'd255};
        4:       c = {8'd43,  8'd210, 8'd255};
        5:       c = {8'd28,  8'd255, 8'd255};
        default: c = {8'd0,   8'd255, 8'd255};
      endcase
    end
    return c;
  endfunction

  task automatic paint_frame(input logic [6:0][7:0] amp, input logic [2:0] mode);
    int          peak;
    int          groups;
    int          spare;
    int          half;
    int          odd;
    int          level;
    int          b;
    int          k;
    logic [23:0] c;
    led_color_t  px;
    peak   = 0;
    groups = LED_COUNT / 7;
    spare  = LED_COUNT - 7 * groups;
    half   = LED_COUNT / 2;
    odd    = LED_COUNT % 2;
    for (int j = 0; j < 7; j++) begin
      if (int'(amp[j]) > peak) peak = int'(amp[j]);
    end
    for (int i = 0; i < LED_COUNT; i++) begin
      px.led_index = 6'(i);
      px.last_led  = (i == LED_COUNT - 1);
      case (mode)
        MODE_RB_VIOLET, MODE_RB_RED: begin
          // band 0 also takes the leftover leds
          if (i < groups + spare) b = 0;
          else b = (i - spare) / ((groups == 0) ? 1 : groups);
          if (b > 6) b = 6;
          c = band_hsv(mode == MODE_RB_RED, b);
          px.hue        = c[23:16];
          px.saturation = c[15:8];
          px.brightness = 8'((int'(amp[b]) * int'(c[7:0])) / 255);
        end
        MODE_LEVEL_BAR: begin
          level         = (peak * LED_COUNT) / 255;
          px.hue        = gradient_hue(i, LED_COUNT);
          px.saturation = 8'd255;
          px.brightness = (i < level) ? 8'd255 : 8'd0;
        end
        MODE_CENTRE_BAR: begin
          level = (peak * half) / 255;
          px.saturation = 8'd255;
          if (odd == 1 && i == half) begin
            px.hue        = 8'd85;
            px.brightness = (level == 0) ? 8'd0 : 8'd255;
          end else begin
            k = (i < half) ? half - 1 - i : i - half - odd;
            px.hue        = gradient_hue(k, half);
            px.brightness = (k < level) ? 8'd255 : 8'd0;
          end
        end
        default: begin
          px.hue        = 8'd0;
          px.saturation = 8'd0;
          px.brightness = 8'd0;
        end
      endcase
      expected_colors.push_back(px);
    end
  endtask

  always @(posedge clk) begin
    led_color_t want;
    led_color_t got;
    if (rst) begin
      display_mode = MODE_OFF;
      expected_colors.delete();
      errors   = 0;
      reported = 0;
    end else begin
      if (cfg_we) display_mode = cfg_wdata;
      if (frame.valid && frame.ready) begin
        paint_frame({frame.band6_level, frame.band5_level, frame.band4_level,
                     frame.band3_level, frame.band2_level, frame.band1_level,
                     frame.band0_level}, display_mode);
      end
      if (pixel.valid && pixel.ready) begin
        got = {pixel.led_index, pixel.hue, pixel.saturation, pixel.brightness,
               pixel.last_led};
        if (expected_colors.size() == 0) begin
          errors++;
          if (reported < 10) begin
            $display("%0t: color transfer with nothing expected: led %0d h %0d s %0d v %0d l %0d",
                     $realtime, got.led_index, got.hue, got.saturation, got.brightness,
                     got.last_led);
            reported++;
          end
        end else begin
          want = expected_colors.pop_front();
          if (got.led_index !== want.led_index || got.hue !== want.hue ||
              got.saturation !== want.saturation || got.brightness !== want.brightness ||
              got.last_led !== want.last_led) begin
            errors++;
            if (reported < 10) begin
              $display("%0t: color mismatch, expected led %0d h %0d s %0d v %0d l %0d",
                       $realtime, want.led_index, want.hue, want.saturation,
                       want.brightness, want.last_led);
              $display("%0t:                 actual   led %0d h %0d s %0d v %0d l %0d",
                       $realtime, got.led_index, got.hue, got.saturation, got.brightness,
                       got.last_led);
              reported++;
            end
          end
        end
      end
    end
    pending    <= expected_colors.size();
    fail_count <= errors;
  end

endmodule

@@ test/tb.sv @@
// tb.sv: stimulus, flow control and verdict for the spectrum frame painter core
`timescale 1ns / 1ps

module tb;
  import lsfp_pkg::*;

  localparam int LED_COUNT = 30;

  // modes 5 to 7 have no function and paint black
  localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
  localparam logic [2:0] MODE_SPARE_MID = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI  = 3'd7;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [2:0] cfg_wdata;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  int         hold_asked = 0;
  int         fail_count;
  int         pending;

  logic [2:0] phase_modes [12] = '{MODE_LEVEL_BAR, MODE_CENTRE_BAR, MODE_RB_VIOLET,
                                   MODE_RB_RED, MODE_OFF, MODE_CENTRE_BAR,
                                   MODE_LEVEL_BAR, MODE_RB_RED, MODE_CENTRE_BAR,
                                   MODE_SPARE_HI, MODE_RB_VIOLET, MODE_LEVEL_BAR};

  lsfp_frame_if frame_ch ();
  lsfp_pixel_if pixel_ch ();

  led_spectrum_frame_painter_core #(
    .LED_COUNT(LED_COUNT)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .frame    (frame_ch),
    .pixel    (pixel_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  lsfp_color_checker #(
    .LED_COUNT(LED_COUNT)
  ) i_checker (
    .clk       (clk),
    .rst       (rst),
    .frame     (frame_ch),
    .pixel     (pixel_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb failed");
    $finish;
  end

  // pixel receiver, with one long hold-off
  initial begin : pixel_sink
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    pixel_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        pixel_ch.ready <= 1'b0;
      end else begin
        pixel_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic [6:0][7:0] random_frame();
    logic [6:0][7:0] b;
    int              shape;
    shape = $urandom_range(9);
    for (int j = 0; j < 7; j++) begin
      case (shape)
        5:       b[j] = 8'($urandom_range(24));
        6:       b[j] = 8'h00;
        7:       b[j] = 8'hFF;
        8, 9:    b[j] = 8'($urandom_range(255, 128));
        default: b[j] = 8'($urandom);
      endcase
    end
    if (shape == 6) b[$urandom_range(6)] = 8'($urandom);
    return b;
  endfunction

  task automatic send_frame(input logic [6:0][7:0] b);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      frame_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    frame_ch.valid       <= 1'b1;
    frame_ch.band0_level <= b[0];
    frame_ch.band1_level <= b[1];
    frame_ch.band2_level <= b[2];
    frame_ch.band3_level <= b[3];
    frame_ch.band4_level <= b[4];
    frame_ch.band5_level <= b[5];
    frame_ch.band6_level <= b[6];
    do @(posedge clk); while (!frame_ch.ready);
  endtask

  // mode changes only once the painter has drained
  task automatic write_mode(input logic [2:0] m);
    frame_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_rainbow_set();
    send_frame({7{8'hFF}});
    send_frame({7{8'h00}});
    send_frame({8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01});
    send_frame({8'hBF, 8'hDF, 8'hEF, 8'hF7, 8'hFB, 8'hFD, 8'hFE});
  endtask

  initial begin
    int wait_cycles;
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_wdata            <= MODE_OFF;
    frame_ch.valid       <= 1'b0;
    frame_ch.band0_level <= 8'h00;
    frame_ch.band1_level <= 8'h00;
    frame_ch.band2_level <= 8'h00;
    frame_ch.band3_level <= 8'h00;
    frame_ch.band4_level <= 8'h00;
    frame_ch.band5_level <= 8'h00;
    frame_ch.band6_level <= 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed frames
    write_mode(MODE_OFF);
    send_frame({7{8'hFF}});
    write_mode(MODE_RB_VIOLET);
    send_rainbow_set();
    write_mode(MODE_RB_RED);
    send_rainbow_set();
    // level thresholds: first lit led and full bar
    write_mode(MODE_LEVEL_BAR);
    send_frame({7{8'h00}});
    send_frame({8'd8, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
    send_frame({8'd0, 8'd0, 8'd0, 8'd9, 8'd0, 8'd0, 8'd0});
    send_frame({7{8'hFF}});
    write_mode(MODE_CENTRE_BAR);
    send_frame({7{8'h00}});
    send_frame({8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd16});
    send_frame({8'd0, 8'd17, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
    send_frame({7{8'hFF}});
    send_frame({7{8'h80}});
    write_mode(MODE_SPARE_LO);
    send_frame({7{8'hFF}});
    write_mode(MODE_SPARE_MID);
    send_frame({7{8'hFF}});
    write_mode(MODE_SPARE_HI);
    send_frame({7{8'hFF}});

    // random frames, one mode and one flow pattern per phase
    for (int p = 0; p < 12; p++) begin
      write_mode(phase_modes[p]);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 66;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 66;
        end
        default: begin
          send_idle_pct = 26;
          stall_pct     = 26;
        end
      endcase
      // long receiver hold-off while frames keep coming
      if (p == 8) hold_asked++;
      repeat (30) send_frame(random_frame());
    end

    frame_ch.valid <= 1'b0;
    @(posedge clk);
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
